### design/edf_pkg.sv
// Shared constants and controller/datapath interface types for the EDF task selector.
package edf_pkg;

    localparam int TASKS_DEF = 16;
    localparam int DL_W      = 31;
    localparam int TASK_W    = 4;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic write;   // store the update item into the slot tables
        logic init;    // latch current task, clear search state, rewind scan index
        logic issue;   // read one slot at the scan index and advance
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;    // scan index sits on the highest slot
    } t_ctrl_sts;

endpackage

### design/edf_ctrl.sv
// Sequencing state machine for update and schedule items.
module edf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_op,
    input  edf_pkg::t_ctrl_sts i_sts,
    output edf_pkg::t_ctrl_cmd o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import edf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd.write = 1'b0;
        o_cmd.init  = 1'b0;
        o_cmd.issue = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_SCHEDULE) begin
                        o_cmd.init = 1'b1;
                        n_state    = ST_SCAN;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

### design/edf_dpath.sv
// Slot tables and the one-slot-per-cycle earliest-deadline search.
module edf_dpath #(
    parameter int TASKS = edf_pkg::TASKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  edf_pkg::t_ctrl_cmd          i_cmd,
    output edf_pkg::t_ctrl_sts          o_sts,
    input  logic [edf_pkg::TASK_W-1:0]  i_slot,
    input  logic                        i_slot_ready,
    input  logic [edf_pkg::DL_W-1:0]    i_slot_deadline,
    input  logic [edf_pkg::TASK_W-1:0]  i_current_task,
    output logic [edf_pkg::TASK_W-1:0]  o_next_task,
    output logic                        o_tie_broken,
    output logic                        o_none_ready
);
    import edf_pkg::*;

    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = (IW > TASK_W) ? IW : TASK_W;

    logic [DL_W-1:0]   mem_dl [TASKS];
    logic [TASKS-1:0]  r_ready;

    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_rd_idx;
    logic              r_rd_vld;
    logic              r_rd_rdy;
    logic [DL_W-1:0]   r_rd_dl;

    logic [TASK_W-1:0] r_cur;
    logic              r_found;
    logic [DL_W-1:0]   r_best;
    logic [IW-1:0]     r_first;
    logic [IW-1:0]     r_after;
    logic              r_have_after;
    logic              r_multi;

    logic [CW-1:0]     slot_ext;
    logic [IW-1:0]     waddr;
    logic              slot_in_range;
    logic              after_cur;
    logic [CW-1:0]     pick_ext;

    assign slot_ext      = CW'(i_slot);
    assign waddr         = slot_ext[IW-1:0];
    assign slot_in_range = (32'(i_slot) < 32'(TASKS));
    assign after_cur     = (CW'(r_rd_idx) > CW'(r_cur));
    assign o_sts.last    = (r_idx == IW'(TASKS - 1));

    // Ready flags: only an update sets one, and it writes the deadline too,
    // so a ready slot never reads a deadline that was not written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
        end else if (i_cmd.write && slot_in_range) begin
            r_ready[waddr] <= i_slot_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && slot_in_range) begin
            mem_dl[waddr] <= i_slot_deadline;
        end
        if (i_cmd.issue) begin
            r_rd_dl <= mem_dl[r_idx];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
        end
        if (i_cmd.init) begin
            r_idx <= IW'(1);
            r_cur <= i_current_task;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.issue) begin
            r_rd_idx <= r_idx;
            r_rd_rdy <= r_ready[r_idx];
        end
    end

    // compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_found      <= 1'b0;
            r_multi      <= 1'b0;
            r_have_after <= 1'b0;
        end else if (r_rd_vld && r_rd_rdy) begin
            if (!r_found || (r_rd_dl < r_best)) begin
                r_found      <= 1'b1;
                r_best       <= r_rd_dl;
                r_first      <= r_rd_idx;
                r_after      <= r_rd_idx;
                r_have_after <= after_cur;
                r_multi      <= 1'b0;
            end else if (r_rd_dl == r_best) begin
                r_multi <= 1'b1;
                if (!r_have_after && after_cur) begin
                    r_after      <= r_rd_idx;
                    r_have_after <= 1'b1;
                end
            end
        end
    end

    // first tied slot after the current task, else the lowest tied slot
    assign pick_ext     = r_have_after ? CW'(r_after) : CW'(r_first);
    assign o_next_task  = r_found ? pick_ext[TASK_W-1:0] : '0;
    assign o_tie_broken = r_found && r_multi;
    assign o_none_ready = !r_found;

endmodule

### design/edf_task_selector_core.sv
// Top level of the earliest-deadline-first task selector with round-robin ties.
// Update item (op 0): written at the accepting edge, busy stays low, one item per cycle while not busy.
// Schedule item (op 1): busy through the scan (slots 1..TASKS-1 one per cycle), drain and done states;
//   o_done strobes in the done state, and the next item is accepted only once the block is idle again.
// The receiver cannot stall; o_done is high for exactly one cycle and results hold until the next schedule item.
// Synchronous active-low reset clears all ready flags and returns to idle.
module edf_task_selector_core #(
    parameter int TASKS = edf_pkg::TASKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [edf_pkg::TASK_W-1:0]  i_slot,
    input  logic                        i_slot_ready,
    input  logic [edf_pkg::DL_W-1:0]    i_slot_deadline,
    input  logic [edf_pkg::TASK_W-1:0]  i_current_task,
    output logic                        o_done,
    output logic [edf_pkg::TASK_W-1:0]  o_next_task,
    output logic                        o_tie_broken,
    output logic                        o_none_ready
);
    import edf_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // Controller: idle / scan / drain / done sequencing.
    edf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Datapath: slot tables, scan counter and running minimum with tie tracking.
    edf_dpath #(
        .TASKS (TASKS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_slot          (i_slot),
        .i_slot_ready    (i_slot_ready),
        .i_slot_deadline (i_slot_deadline),
        .i_current_task  (i_current_task),
        .o_next_task     (o_next_task),
        .o_tie_broken    (o_tie_broken),
        .o_none_ready    (o_none_ready)
    );

endmodule
